/* src/trp_pkg.sv */
// telnet receive parser package: parser states, protocol codes and the decode result struct
// used by trp_decode and telnet_receive_parser; depends on nothing
`default_nettype none

package trp_pkg;

	localparam int unsigned MAX_OPTION = 39;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CODE_IAC  = 8'd255;
	localparam logic [7:0] CODE_DONT = 8'd254;
	localparam logic [7:0] CODE_DO   = 8'd253;
	localparam logic [7:0] CODE_WONT = 8'd252;
	localparam logic [7:0] CODE_WILL = 8'd251;
	localparam logic [7:0] CODE_AYT  = 8'd246;
	localparam logic [7:0] OPT_ECHO  = 8'd1;
	localparam logic [7:0] OPT_SGA   = 8'd3;
	localparam logic [7:0] OPT_LAST  = 8'(MAX_OPTION);

	typedef enum logic [1:0] {
		VERB_WILL = 2'd0,
		VERB_WONT = 2'd1,
		VERB_DO   = 2'd2,
		VERB_DONT = 2'd3
	} verb_t;

	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_REPLY = 2'd1,
		KIND_AYT   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_DATA = 3'd0,
		ST_CR   = 3'd1,
		ST_IAC  = 3'd2,
		ST_WILL = 3'd3,
		ST_WONT = 3'd4,
		ST_DO   = 3'd5,
		ST_DONT = 3'd6
	} parse_state_t;

	typedef struct packed {
		logic         echo;
		logic         sga;
	} marks_t;

	typedef struct packed {
		logic         emit;
		kind_t        kind;
		logic [7:0]   value;
		verb_t        verb;
		parse_state_t next_state;
		marks_t       next_marks;
	} decode_t;

endpackage

`default_nettype wire

/* src/trp_decode.sv */
// telnet receive parser: per-item decode of one byte against parser state and option marks
// depends on trp_pkg
`default_nettype none

module trp_decode (
	input  wire trp_pkg::parse_state_t state,
	input  wire trp_pkg::marks_t       marks,
	input  wire logic [7:0]            rx_byte,
	output trp_pkg::decode_t           dec
);

	logic is_echo;
	logic is_sga;
	logic above_max;

	assign is_echo   = (rx_byte == trp_pkg::OPT_ECHO);
	assign is_sga    = (rx_byte == trp_pkg::OPT_SGA);
	assign above_max = (rx_byte > trp_pkg::OPT_LAST);

	always_comb begin
		dec            = '0;
		dec.kind       = trp_pkg::KIND_DATA;
		dec.verb       = trp_pkg::VERB_WILL;
		dec.value      = rx_byte;
		dec.next_state = trp_pkg::ST_DATA;
		dec.next_marks = marks;
		unique case (state)
			trp_pkg::ST_IAC: begin
				if (rx_byte == trp_pkg::CODE_WILL) begin
					dec.next_state = trp_pkg::ST_WILL;
				end else if (rx_byte == trp_pkg::CODE_WONT) begin
					dec.next_state = trp_pkg::ST_WONT;
				end else if (rx_byte == trp_pkg::CODE_DO) begin
					dec.next_state = trp_pkg::ST_DO;
				end else if (rx_byte == trp_pkg::CODE_DONT) begin
					dec.next_state = trp_pkg::ST_DONT;
				end else if (rx_byte == trp_pkg::CODE_AYT) begin
					dec.emit  = 1'b1;
					dec.kind  = trp_pkg::KIND_AYT;
					dec.value = '0;
				end else if (rx_byte == trp_pkg::CODE_IAC) begin
					dec.emit = 1'b1;
				end
			end
			trp_pkg::ST_WILL: begin
				dec.emit = 1'b1;
				dec.kind = trp_pkg::KIND_REPLY;
				dec.verb = trp_pkg::VERB_DONT;
			end
			trp_pkg::ST_WONT: begin
				// remote marks are never set, so only unkept options get a reply
				dec.emit = above_max;
				dec.kind = trp_pkg::KIND_REPLY;
				dec.verb = trp_pkg::VERB_DONT;
			end
			trp_pkg::ST_DO: begin
				dec.kind = trp_pkg::KIND_REPLY;
				priority if (is_echo) begin
					dec.emit            = !marks.echo;
					dec.next_marks.echo = 1'b1;
				end else if (is_sga) begin
					dec.emit           = !marks.sga;
					dec.next_marks.sga = 1'b1;
				end else begin
					dec.emit = 1'b1;
					dec.verb = trp_pkg::VERB_WONT;
				end
			end
			trp_pkg::ST_DONT: begin
				dec.kind = trp_pkg::KIND_REPLY;
				dec.verb = trp_pkg::VERB_WONT;
				if (above_max) begin
					dec.emit = 1'b1;
				end else if (is_echo) begin
					dec.emit            = marks.echo;
					dec.next_marks.echo = 1'b0;
				end else if (is_sga) begin
					dec.emit           = marks.sga;
					dec.next_marks.sga = 1'b0;
				end
			end
			default: begin
				// data state, after-cr state and unused codes
				if (state == trp_pkg::ST_CR &&
						(rx_byte == trp_pkg::CH_NUL || rx_byte == trp_pkg::CH_LF)) begin
					dec.emit = 1'b0;
				end else if (rx_byte == trp_pkg::CODE_IAC) begin
					dec.next_state = trp_pkg::ST_IAC;
				end else begin
					dec.emit       = 1'b1;
					dec.next_state = (rx_byte == trp_pkg::CH_CR) ? trp_pkg::ST_CR
						: trp_pkg::ST_DATA;
				end
			end
		endcase
	end

endmodule

`default_nettype wire

/* src/telnet_receive_parser.sv */
// Telnet receive parser: one received byte per item in, at most one result item out.
// An input register feeds the byte decode (state plus two option marks, echo and
// suppress-go-ahead) and the result lands in an output register, so a new byte is taken
// every cycle while the output side keeps up. Items that give no result are absorbed in
// the decode stage. Depends on trp_pkg and trp_decode.
`default_nettype none

module telnet_receive_parser (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire [7:0]  rx_byte,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [1:0] kind,
	output logic [7:0] value,
	output logic [1:0] verb
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	trp_pkg::parse_state_t state_q;
	trp_pkg::marks_t       marks_q;
	trp_pkg::decode_t      dec;
	logic                  out_valid_q;
	logic [1:0]            kind_q;
	logic [7:0]            value_q;
	logic [1:0]            verb_q;
	logic                  advance;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	trp_decode u_decode (
		.state   (state_q),
		.marks   (marks_q),
		.rx_byte (byte_s1),
		.dec     (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= trp_pkg::ST_DATA;
			marks_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && dec.emit;
			if (valid_s1) begin
				state_q <= dec.next_state;
				marks_q <= dec.next_marks;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1 && dec.emit) begin
			kind_q  <= dec.kind;
			value_q <= dec.value;
			verb_q  <= (dec.kind == trp_pkg::KIND_REPLY) ? dec.verb : trp_pkg::VERB_WILL;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign value     = value_q;
	assign verb      = verb_q;

endmodule

`default_nettype wire
